>>> hdl/block_buffer_cache_lru_top_defines.svh
// Assertion macros shared by the buffer cache RTL
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_DEFINES_SVH

// Check that a condition implies another one in the same cycle
`define BBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bbc_pkg.sv
// Types, constants and codes of the LRU block buffer cache
package bbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int IDX_W       = $clog2(NUM_BUFFERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DEV_W       = 8;
  localparam int BLK_W       = 32;
  localparam int REF_W       = 8;
  localparam int REL_W       = 5;
  localparam int STATUS_W    = 2;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_UNHELD  = 2'd2
  } status_t;

  // One buffer entry as kept in the entry memory
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic             valid;
    logic [REF_W-1:0] refs;
    logic [IDX_W-1:0] rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Best candidates found by a tag walk
  typedef struct packed {
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    entry_t           hit_entry;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    entry_t           free_entry;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACQ_SCAN,
    ST_ACQ_WRITE,
    ST_REL_CHECK,
    ST_REL_SWEEP,
    ST_DONE
  } state_t;

endpackage

>>> hdl/bbc_if.sv
// Request and response channel interfaces of the buffer cache
interface bbc_req_if import bbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [DEV_W-1:0] device;
  logic [BLK_W-1:0] block_number;
  logic [REL_W-1:0] release_index;

  modport source (output valid, opcode, device, block_number, release_index, input ready);
  modport sink   (input valid, opcode, device, block_number, release_index, output ready);
endinterface

interface bbc_rsp_if import bbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [REL_W-1:0]    buffer_index;
  logic                needs_read;
  logic                was_hit;

  modport source (output valid, status, buffer_index, needs_read, was_hit, input ready);
  modport sink   (input valid, status, buffer_index, needs_read, was_hit, output ready);
endinterface

>>> hdl/block_buffer_cache_lru_top.sv
// Top level of the LRU block buffer cache: sequencer around the entry memory
//
//   Channel  Dir  Payload                                        Accepted when
//   req      in   opcode, device, block_number, release_index    req.valid && req.ready
//   rsp      out  status, buffer_index, needs_read, was_hit      rsp.valid && rsp.ready
//
// An acquire walks all NUM_BUFFERS entries through the single read port of the
// entry memory before its result is formed. A release walks and rewrites the
// recency ranks only when its count drops to zero. One item is in work at a
// time. After reset a clearing pass writes the reset entries with req.ready
// low. A stalled result waits in the output register while the next item is
// accepted and worked on.
`include "block_buffer_cache_lru_top_defines.svh"

module block_buffer_cache_lru_top import bbc_pkg::*; (
  input logic      clk,
  input logic      rst,
  bbc_req_if.sink  req,
  bbc_rsp_if.source rsp
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  logic [DEV_W-1:0] op_dev;
  logic [BLK_W-1:0] op_blk;
  logic [REL_W-1:0] rel_raw;
  logic [IDX_W-1:0] rel_addr;
  logic [IDX_W-1:0] rel_rank;

  status_t          res_status;
  logic [REL_W-1:0] res_index;
  logic             res_read;
  logic             res_hit;

  logic             out_valid;
  status_t          out_status;
  logic [REL_W-1:0] out_index;
  logic             out_read;
  logic             out_hit;

  logic             accept;
  logic             out_free;
  logic             issue;
  logic             scan_clear;
  logic             walk_end;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_rword;
  entry_t           mem_rdata;
  scan_res_t        scan_res;

  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign rel_addr  = IDX_W'(rel_raw);
  assign walk_end  = (cnt == CNT_W'(NUM_BUFFERS));
  assign mem_rdata = entry_t'(mem_rword);

  bbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUFFERS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rword)
  );

  bbc_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .clear  (scan_clear),
    .sample (rd_pend && (state == ST_ACQ_SCAN)),
    .idx    (rd_idx),
    .data   (mem_rdata),
    .dev    (op_dev),
    .blk    (op_blk),
    .res    (scan_res)
  );

  // Next state and memory port control
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    issue      = 1'b0;
    scan_clear = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx;
    mem_wdata  = mem_rdata;
    mem_raddr  = cnt[IDX_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = cnt[IDX_W-1:0];
        mem_wdata.dev  = '0;
        mem_wdata.blk  = '0;
        mem_wdata.valid = 1'b0;
        mem_wdata.refs = '0;
        mem_wdata.rank = IDX_W'(NUM_BUFFERS - 1) - cnt[IDX_W-1:0];
        if (cnt == CNT_W'(NUM_BUFFERS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready  = 1'b1;
        scan_clear = 1'b1;
        mem_raddr  = IDX_W'(req.release_index);
        if (accept) begin
          if (req.opcode == OP_RELEASE) begin
            if (int'(req.release_index) < NUM_BUFFERS) begin
              state_next = ST_REL_CHECK;
            end else begin
              state_next = ST_DONE;
            end
          end else begin
            state_next = ST_ACQ_SCAN;
          end
        end
      end
      ST_ACQ_SCAN: begin
        issue = !walk_end;
        if (walk_end) begin
          state_next = ST_ACQ_WRITE;
        end
      end
      ST_ACQ_WRITE: begin
        // Hit: bump the count; miss: retag the free entry, rank unchanged
        if (scan_res.hit_found) begin
          mem_we          = 1'b1;
          mem_waddr       = scan_res.hit_idx;
          mem_wdata       = scan_res.hit_entry;
          mem_wdata.valid = 1'b1;
          if (scan_res.hit_entry.refs != REF_MAX) begin
            mem_wdata.refs = scan_res.hit_entry.refs + 1'b1;
          end
        end else if (scan_res.free_found) begin
          mem_we          = 1'b1;
          mem_waddr       = scan_res.free_idx;
          mem_wdata       = scan_res.free_entry;
          mem_wdata.dev   = op_dev;
          mem_wdata.blk   = op_blk;
          mem_wdata.valid = 1'b1;
          mem_wdata.refs  = REF_W'(1);
        end
        state_next = ST_DONE;
      end
      ST_REL_CHECK: begin
        if (mem_rdata.refs == '0) begin
          state_next = ST_DONE;
        end else if (mem_rdata.refs == REF_W'(1)) begin
          state_next = ST_REL_SWEEP;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = rel_addr;
          mem_wdata.refs = mem_rdata.refs - 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_REL_SWEEP: begin
        // Age the entries more recent than the released one, move it to front
        issue = !walk_end;
        if (rd_pend) begin
          mem_we = 1'b1;
          if (rd_idx == rel_addr) begin
            mem_wdata.rank = '0;
            mem_wdata.refs = '0;
          end else if (mem_rdata.rank < rel_rank) begin
            mem_wdata.rank = mem_rdata.rank + 1'b1;
          end
        end
        if (walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_CLEAR || issue) begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, result forming and output register
  always_ff @(posedge clk) begin
    rd_idx <= cnt[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_dev     <= req.device;
          op_blk     <= req.block_number;
          rel_raw    <= req.release_index;
          res_status <= STATUS_UNHELD;
          res_index  <= req.release_index;
          res_read   <= 1'b0;
          res_hit    <= 1'b0;
        end
      end
      ST_ACQ_WRITE: begin
        if (scan_res.hit_found) begin
          res_status <= STATUS_OK;
          res_index  <= REL_W'(scan_res.hit_idx);
          res_read   <= !scan_res.hit_entry.valid;
          res_hit    <= 1'b1;
        end else if (scan_res.free_found) begin
          res_status <= STATUS_OK;
          res_index  <= REL_W'(scan_res.free_idx);
          res_read   <= 1'b1;
          res_hit    <= 1'b0;
        end else begin
          res_status <= STATUS_NO_FREE;
          res_index  <= '0;
          res_read   <= 1'b0;
          res_hit    <= 1'b0;
        end
      end
      ST_REL_CHECK: begin
        rel_rank <= mem_rdata.rank;
        if (mem_rdata.refs != '0) begin
          res_status <= STATUS_OK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_status <= res_status;
          out_index  <= res_index;
          out_read   <= res_read;
          out_hit    <= res_hit;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.buffer_index = out_index;
  assign rsp.needs_read   = out_read;
  assign rsp.was_hit      = out_hit;

  `BBC_ASSERT_IMP(a_we_states, clk, rst, mem_we, (state == ST_CLEAR || state == ST_ACQ_WRITE || state == ST_REL_CHECK || state == ST_REL_SWEEP), "entry memory written outside a writing state")
  `BBC_ASSERT_IMP(a_rel_front, clk, rst, (state == ST_REL_SWEEP && rd_pend && rd_idx == rel_addr), (mem_we && mem_wdata.rank == '0 && mem_wdata.refs == '0), "released entry not moved to front")
  `BBC_ASSERT_IMP(a_hit_write, clk, rst, (state == ST_ACQ_WRITE && scan_res.hit_found), (mem_we && mem_waddr == scan_res.hit_idx && mem_wdata.valid), "hit entry not written back")
  `BBC_ASSERT_NEXT(a_busy, clk, rst, accept, (state != ST_IDLE), "accepted item left no work in progress")

endmodule

>>> hdl/bbc_ram.sv
// Simple dual-port synchronous RAM with registered read data
module bbc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bbc_scan.sv
// Tag walk tracker: most recent matching entry and least recent free entry
module bbc_scan import bbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             sample,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           data,
  input  logic [DEV_W-1:0] dev,
  input  logic [BLK_W-1:0] blk,
  output scan_res_t        res
);

  logic take_hit;
  logic take_free;

  // Compare one entry against the current best candidates
  always_comb begin
    take_hit  = (data.dev == dev) && (data.blk == blk) &&
                (!res.hit_found || (data.rank < res.hit_entry.rank));
    take_free = (data.refs == '0) &&
                (!res.free_found || (data.rank > res.free_entry.rank));
  end

  // Hold the best candidates over the walk
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.hit_found  <= 1'b0;
      res.free_found <= 1'b0;
    end else if (sample) begin
      if (take_hit) begin
        res.hit_found <= 1'b1;
        res.hit_idx   <= idx;
        res.hit_entry <= data;
      end
      if (take_free) begin
        res.free_found <= 1'b1;
        res.free_idx   <= idx;
        res.free_entry <= data;
      end
    end
  end

endmodule

>>> verif/lru_cache_shadow_pkg.sv
`timescale 1ns / 100ps
// Shadow copy of the cache tag state that predicts and checks each result item
package lru_cache_shadow_pkg;
  import bbc_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [REL_W-1:0] buffer_index;
    logic             needs_read;
    logic             was_hit;
  } cache_outcome_t;

  class lru_cache_shadow;
    logic [DEV_W-1:0] tag_dev [NUM_BUFFERS];
    logic [BLK_W-1:0] tag_blk [NUM_BUFFERS];
    logic             present [NUM_BUFFERS];
    logic [REF_W-1:0] refs    [NUM_BUFFERS];
    logic [IDX_W-1:0] rank    [NUM_BUFFERS];
    cache_outcome_t   pending_outcomes [$];
    int unsigned      mismatches, hits, misses, no_free, unheld, saturated, releases;

    function new();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        present[i] = 1'b0;
        refs[i]    = '0;
        rank[i]    = IDX_W'(NUM_BUFFERS - 1 - i);
      end
      mismatches = 0;
      hits       = 0;
      misses     = 0;
      no_free    = 0;
      unheld     = 0;
      saturated  = 0;
      releases   = 0;
    endfunction

    // Return the matching entry with the smallest rank, or -1
    function int find_tag(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
      int found;
      found = -1;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (tag_dev[i] == dev && tag_blk[i] == blk && (found < 0 || rank[i] < rank[found]))
          found = i;
      end
      return found;
    endfunction

    // Move an entry to rank zero and age the ones that were more recent
    function void make_most_recent(int e);
      logic [IDX_W-1:0] old_rank;
      old_rank = rank[e];
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (rank[i] < old_rank) rank[i] = rank[i] + 1'b1;
      end
      rank[e] = '0;
    endfunction

    // Update the state for one accepted item and queue its result
    function void note_request(opcode_t op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                               logic [REL_W-1:0] rel);
      cache_outcome_t res;
      int             e;
      res.status       = STATUS_OK;
      res.buffer_index = '0;
      res.needs_read   = 1'b0;
      res.was_hit      = 1'b0;
      if (op == OP_RELEASE) begin
        res.buffer_index = rel;
        if (int'(rel) >= NUM_BUFFERS || refs[rel] == '0) begin
          res.status = STATUS_UNHELD;
          unheld++;
        end else begin
          refs[rel] = refs[rel] - 1'b1;
          if (refs[rel] == '0) make_most_recent(int'(rel));
          releases++;
        end
      end else begin
        e = find_tag(dev, blk);
        if (e >= 0) begin
          res.buffer_index = REL_W'(e);
          res.needs_read   = !present[e];
          res.was_hit      = 1'b1;
          if (refs[e] != REF_MAX) refs[e] = refs[e] + 1'b1;
          else saturated++;
          present[e] = 1'b1;
          hits++;
        end else begin
          // Recycle the least recently used unreferenced entry
          for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (refs[i] == '0 && (e < 0 || rank[i] > rank[e])) e = i;
          end
          if (e < 0) begin
            res.status = STATUS_NO_FREE;
            no_free++;
          end else begin
            tag_dev[e]       = dev;
            tag_blk[e]       = blk;
            refs[e]          = REF_W'(1);
            present[e]       = 1'b1;
            res.buffer_index = REL_W'(e);
            res.needs_read   = 1'b1;
            misses++;
          end
        end
      end
      pending_outcomes.push_back(res);
    endfunction

    // Compare one result item with the oldest expected one
    function void check_outcome(logic [STATUS_W-1:0] status, logic [REL_W-1:0] idx,
                                logic rd, logic hit);
      cache_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result item with none expected: status %0d buffer_index %0d", status, idx);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (idx !== want.buffer_index) begin
        $error("buffer_index: expected %0d, actual %0d", want.buffer_index, idx);
        mismatches++;
      end
      if (rd !== want.needs_read) begin
        $error("needs_read: expected %0d, actual %0d", want.needs_read, rd);
        mismatches++;
      end
      if (hit !== want.was_hit) begin
        $error("was_hit: expected %0d, actual %0d", want.was_hit, hit);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

endpackage

>>> verif/block_buffer_cache_lru_top_test.sv
`timescale 1ns / 100ps
// Testbench top of the LRU block buffer cache: stimulus, handshakes and checking
module block_buffer_cache_lru_top_test;
  import bbc_pkg::*;
  import lru_cache_shadow_pkg::*;

  localparam int ITEM_TARGET    = 1250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 2 * NUM_BUFFERS + 8;
  localparam int POOL_SIZE      = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbc_req_if req ();
  bbc_rsp_if rsp ();

  lru_cache_shadow  shadow;
  bit               steady;
  bit               offering;
  int               next_gap;
  int               hold_request;
  int               items_sent;
  int               idle_cycles = 0;
  logic [DEV_W-1:0] pool_dev [POOL_SIZE];
  logic [BLK_W-1:0] pool_blk [POOL_SIZE];

  block_buffer_cache_lru_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Offer one item, hold it until accepted, then note it
  task automatic send_item(opcode_t op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                           logic [REL_W-1:0] rel);
    repeat (next_gap) @(posedge clk);
    req.valid         <= 1'b1;
    req.opcode        <= op;
    req.device        <= dev;
    req.block_number  <= blk;
    req.release_index <= rel;
    offering = 1'b1;
    do @(posedge clk); while (!req.ready);
    shadow.note_request(op, dev, blk, rel);
    items_sent++;
    next_gap = draw_gap();
    if (next_gap > 0) begin
      req.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic acquire_block(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
    send_item(OP_ACQUIRE, dev, blk, REL_W'($urandom));
  endtask

  task automatic release_buffer(logic [REL_W-1:0] idx);
    send_item(OP_RELEASE, DEV_W'($urandom), $urandom, idx);
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    if (offering) begin
      req.valid <= 1'b0;
      offering = 1'b0;
    end
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  // Pick a tag that no entry holds
  task automatic fresh_tag(output logic [DEV_W-1:0] dev, output logic [BLK_W-1:0] blk);
    do begin
      dev = DEV_W'($urandom);
      blk = $urandom;
    end while (shadow.find_tag(dev, blk) >= 0);
  endtask

  task automatic release_all();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      while (shadow.refs[i] != '0) release_buffer(REL_W'(i));
    end
  endtask

  task automatic run_directed();
    // All tags read as device 0 block 0 after reset: hit on the most recent, read needed
    acquire_block(8'h00, 32'h0000_0000);
    acquire_block(8'h00, 32'h0000_0000);
    release_buffer(5'd31);
    release_buffer(5'd31);
    release_buffer(5'd31);
    release_buffer(5'd0);
    // Misses at the field extremes and on fresh tags, with a repeat that hits
    acquire_block(8'hFF, 32'hFFFF_FFFF);
    acquire_block(8'hFF, 32'hFFFF_FFFF);
    acquire_block(8'h00, 32'hFFFF_FFFF);
    acquire_block(8'hFF, 32'h0000_0000);
    acquire_block(8'hA5, 32'h5A5A_5A5A);
    acquire_block(8'h5A, 32'hA5A5_A5A5);
    // Release to zero and promote, then hit again among several matching tags
    release_buffer(5'd0);
    release_buffer(5'd0);
    acquire_block(8'h00, 32'h0000_0000);
    acquire_block(8'hFF, 32'hFFFF_FFFF);
    release_buffer(5'd31);
    release_buffer(5'd0);
    release_buffer(5'd1);
    release_buffer(5'd2);
    release_buffer(5'd3);
    release_buffer(5'd4);
    release_buffer(5'd16);
    acquire_block(8'h00, 32'h0000_0000);
  endtask

  // Hit one block past the count limit, then release it until unheld
  task automatic saturate_phase();
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    int               e;
    release_all();
    fresh_tag(dev, blk);
    repeat (int'(REF_MAX) + 2) acquire_block(dev, blk);
    e = shadow.find_tag(dev, blk);
    repeat (int'(REF_MAX) + 1) release_buffer(REL_W'(e));
  endtask

  // Hold every entry so that further misses find no free buffer
  task automatic fill_phase();
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    release_all();
    repeat (NUM_BUFFERS + 2) begin
      fresh_tag(dev, blk);
      acquire_block(dev, blk);
    end
    acquire_block(shadow.tag_dev[5], shadow.tag_blk[5]);
    release_all();
  endtask

  // Mix acquires of a small tag pool with releases of held buffers
  task automatic mixed_phase(int count);
    int held [$];
    int pick;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, POOL_SIZE - 1);
          acquire_block(pool_dev[pick], pool_blk[pick]);
        end else begin
          acquire_block(DEV_W'($urandom), $urandom);
        end
      end else begin
        held.delete();
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (shadow.refs[i] != '0) held.push_back(i);
        end
        if (held.size() > 0 && $urandom_range(0, 9) != 0)
          release_buffer(REL_W'(held[$urandom_range(0, held.size() - 1)]));
        else
          release_buffer(REL_W'($urandom));
      end
    end
  endtask

  // Drive the request side
  initial begin
    int phase;
    shadow = new();
    req.valid         <= 1'b0;
    req.opcode        <= OP_ACQUIRE;
    req.device        <= '0;
    req.block_number  <= '0;
    req.release_index <= '0;
    steady       = 1'b0;
    offering     = 1'b0;
    next_gap     = 0;
    hold_request = 0;
    items_sent   = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_dev[i] = DEV_W'($urandom_range(0, 3));
      pool_blk[i] = (i % 3 == 0) ? $urandom : $urandom_range(0, 7);
    end
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain();
    saturate_phase();
    drain();
    fill_phase();
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      // Stall the receiver for a long stretch while items keep coming
      if (phase == 1) begin
        steady       = 1'b1;
        hold_request = HOLD_CYCLES;
      end
      mixed_phase(60);
      if (phase == 2 || $urandom_range(0, 2) == 0) drain();
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d hits, %0d misses, %0d refused for lack of a free buffer",
             items_sent, shadow.hits, shadow.misses, shadow.no_free);
    $display("%0d releases, %0d of unheld buffers, %0d hits at the count limit",
             shadow.releases, shadow.unheld, shadow.saturated);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Drive the result side: random stalls, plus the long hold when asked
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Check result items and watch for a stuck block
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        shadow.check_outcome(rsp.status, rsp.buffer_index, rsp.needs_read, rsp.was_hit);
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
